// ----- src/swpl_pkg.sv -----
// Shared types and constants for the sliding window packet loss core.
// Holds field widths, the divider operand select codes and the
// controller/datapath command and status structs. No dependencies.
package swpl_pkg;

   localparam int TS_W      = 32;
   localparam int FRAME_W   = 16;
   localparam int LEN_W     = 16;
   localparam int LOSS_W    = 14;
   localparam int COUNT_W   = 8;
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 16;

   localparam logic [LEN_W-1:0]     BUCKET_SECONDS_RESET = 16'd900;
   localparam logic [DIV_NUM_W-1:0] BASIS_POINTS         = 32'd10000;

   // operand pair fed to the shared divider
   typedef enum logic [1:0] {
      DIV_TS,     // timestamp / bucket length
      DIV_GAP,    // (bucket - bucket_start) / bucket length
      DIV_AGE,    // age / bucket length
      DIV_RATIO   // lost * 10000 / total
   } div_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        div_start;
      div_sel_type div_sel;
      logic        load_bucket;
      logic        load_cnt;
      logic        shift_one;
      logic        update_newest;
      logic        sum_clear;
      logic        sum_step;
      logic        load_product;
      logic        out_load;
      logic        out_zero;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic div_busy;
      logic div_done;
      logic quo_expired;
      logic bucket_before;
      logic bucket_same;
      logic cnt_zero;
      logic sum_last;
      logic total_zero;
   } status_type;

endpackage

// ----- src/swpl_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Widths come from swpl_pkg; divisor must be nonzero.
module swpl_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [swpl_pkg::DIV_NUM_W-1:0] num,
   input  logic [swpl_pkg::DIV_DEN_W-1:0] den,
   output logic                           busy,
   output logic                           done,
   output logic [swpl_pkg::DIV_NUM_W-1:0] quo,
   output logic [swpl_pkg::DIV_DEN_W-1:0] rem
);

   localparam int NW     = swpl_pkg::DIV_NUM_W;
   localparam int DW     = swpl_pkg::DIV_DEN_W;
   localparam int STEP_W = $clog2(NW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [DW:0]       trial;
   logic [DW:0]       diff;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

// ----- src/swpl_dp.sv -----
// Datapath: bucket window, request and config registers, sums, result register.
// Depends on swpl_pkg and swpl_div; driven by swpl_ctrl commands.
module swpl_dp #(
   parameter int WINDOW_BUCKETS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [swpl_pkg::LEN_W-1:0]         csr_data,
   input  logic                               req_op,
   input  logic [swpl_pkg::TS_W-1:0]          req_timestamp,
   input  logic [swpl_pkg::FRAME_W-1:0]       req_frame,
   input  swpl_pkg::cmd_type                  cmd,
   output swpl_pkg::status_type               status,
   output logic [swpl_pkg::LOSS_W-1:0]        loss
);

   localparam int W     = WINDOW_BUCKETS;
   localparam int IW    = $clog2(W);
   localparam int CW    = $clog2(W + 1);
   localparam int SUM_W = $clog2(W * 255 + 1);
   localparam int TOT_W = SUM_W + 1;
   localparam int CNTW  = swpl_pkg::COUNT_W;
   localparam int NW    = swpl_pkg::DIV_NUM_W;
   localparam int DW    = swpl_pkg::DIV_DEN_W;

   logic [swpl_pkg::LEN_W-1:0]   len_cfg_ff;
   logic [swpl_pkg::LEN_W-1:0]   len;
   logic                         op_ff;
   logic [swpl_pkg::TS_W-1:0]    ts_ff;
   logic [swpl_pkg::FRAME_W-1:0] frame_ff;
   logic [swpl_pkg::FRAME_W-1:0] prev_frame_ff;
   logic [swpl_pkg::TS_W-1:0]    bucket_start_ff;
   logic [swpl_pkg::TS_W-1:0]    bucket_ff;
   logic [CNTW-1:0]              rx_ff   [W];
   logic [CNTW-1:0]              lost_ff [W];
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [IW-1:0]                idx_ff;
   logic [SUM_W-1:0]             rx_sum_ff;
   logic [SUM_W-1:0]             drop_sum_ff;
   logic [NW-1:0]                prod_ff;
   logic [swpl_pkg::LOSS_W-1:0]  loss_ff;

   logic [NW-1:0]                div_num;
   logic [DW-1:0]                div_den;
   logic                         div_busy;
   logic                         div_done;
   logic [NW-1:0]                div_quo;
   logic [DW-1:0]                div_rem;
   logic [TOT_W-1:0]             total;
   logic [swpl_pkg::TS_W-1:0]    age;
   logic [swpl_pkg::FRAME_W-1:0] frame_gap;
   logic                         quo_expired;

   // a zero bucket length acts as one
   assign len = (len_cfg_ff == '0) ? swpl_pkg::LEN_W'(1) : len_cfg_ff;

   assign age       = (ts_ff > bucket_start_ff) ? (ts_ff - bucket_start_ff) : '0;
   assign total     = TOT_W'(rx_sum_ff) + TOT_W'(drop_sum_ff);
   assign frame_gap = frame_ff - prev_frame_ff - 1'b1;
   assign quo_expired = (div_quo >= NW'(W));

   // divider operand select
   always_comb begin
      unique case (cmd.div_sel)
         swpl_pkg::DIV_TS: begin
            div_num = ts_ff;
            div_den = len;
         end
         swpl_pkg::DIV_GAP: begin
            div_num = bucket_ff - bucket_start_ff;
            div_den = len;
         end
         swpl_pkg::DIV_AGE: begin
            div_num = age;
            div_den = len;
         end
         swpl_pkg::DIV_RATIO: begin
            div_num = prod_ff;
            div_den = DW'(total);
         end
         default: begin
            div_num = ts_ff;
            div_den = len;
         end
      endcase
   end

   swpl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // bucket length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= swpl_pkg::BUCKET_SECONDS_RESET;
      end else if (csr_write) begin
         len_cfg_ff <= csr_data;
      end
   end

   // request capture, bucket start, product
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_op;
         ts_ff    <= req_timestamp;
         frame_ff <= req_frame;
      end
      if (cmd.load_bucket) begin
         bucket_ff <= ts_ff - swpl_pkg::TS_W'(div_rem);
      end
      if (cmd.load_product) begin
         prod_ff <= NW'(drop_sum_ff) * swpl_pkg::BASIS_POINTS;
      end
   end

   // shift count, or first bucket of a query, capped at the window size
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load_cnt) begin
         cnt_in = quo_expired ? CW'(W) : div_quo[CW-1:0];
      end else if (cmd.shift_one) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   // window slots: slot W-1 is the newest
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < W; i++) begin
            rx_ff[i]   <= '0;
            lost_ff[i] <= '0;
         end
         bucket_start_ff <= '0;
         prev_frame_ff   <= '0;
      end else if (cmd.shift_one) begin
         for (int i = 0; i < W - 1; i++) begin
            rx_ff[i]   <= rx_ff[i + 1];
            lost_ff[i] <= lost_ff[i + 1];
         end
         rx_ff[W-1]   <= '0;
         lost_ff[W-1] <= '0;
      end else if (cmd.update_newest) begin
         rx_ff[W-1]      <= rx_ff[W-1] + 1'b1;
         lost_ff[W-1]    <= lost_ff[W-1] + frame_gap[CNTW-1:0];
         prev_frame_ff   <= frame_ff;
         bucket_start_ff <= bucket_ff;
      end
   end

   // running sums over slots from the first live bucket on
   always_ff @(posedge clock) begin
      if (cmd.sum_clear) begin
         idx_ff      <= '0;
         rx_sum_ff   <= '0;
         drop_sum_ff <= '0;
      end else if (cmd.sum_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (CW'(idx_ff) >= cnt_ff) begin
            rx_sum_ff   <= rx_sum_ff + SUM_W'(rx_ff[idx_ff]);
            drop_sum_ff <= drop_sum_ff + SUM_W'(lost_ff[idx_ff]);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         loss_ff <= cmd.out_zero ? '0 : div_quo[swpl_pkg::LOSS_W-1:0];
      end
   end

   assign status.op            = op_ff;
   assign status.div_busy      = div_busy;
   assign status.div_done      = div_done;
   assign status.quo_expired   = quo_expired;
   assign status.bucket_before = (bucket_ff < bucket_start_ff);
   assign status.bucket_same   = (bucket_ff == bucket_start_ff);
   assign status.cnt_zero      = (cnt_ff == '0);
   assign status.sum_last      = (idx_ff == IW'(W - 1));
   assign status.total_zero    = (total == '0);

   assign loss = loss_ff;

endmodule

// ----- src/swpl_ctrl.sv -----
// Controller state machine: sequences account and query requests.
// Depends on swpl_pkg; issues commands to swpl_dp and owns rsp_valid.
module swpl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  swpl_pkg::status_type status,
   output swpl_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_START   = 4'd1;
   localparam logic [3:0] ST_A_DIV1  = 4'd2;
   localparam logic [3:0] ST_A_CMP   = 4'd3;
   localparam logic [3:0] ST_A_DIV2  = 4'd4;
   localparam logic [3:0] ST_A_SHIFT = 4'd5;
   localparam logic [3:0] ST_A_UPD   = 4'd6;
   localparam logic [3:0] ST_Q_DIV1  = 4'd7;
   localparam logic [3:0] ST_Q_SUM   = 4'd8;
   localparam logic [3:0] ST_Q_TOT   = 4'd9;
   localparam logic [3:0] ST_Q_MUL   = 4'd10;
   localparam logic [3:0] ST_Q_DIV2  = 4'd11;
   localparam logic [3:0] ST_Q_OUT   = 4'd12;
   localparam logic [3:0] ST_Q_ZERO  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = swpl_pkg::DIV_TS;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_START;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            if (status.op) begin
               cmd.div_sel = swpl_pkg::DIV_AGE;
               state_in    = ST_Q_DIV1;
            end else begin
               cmd.div_sel = swpl_pkg::DIV_TS;
               state_in    = ST_A_DIV1;
            end
         end
         ST_A_DIV1: begin
            if (status.div_done) begin
               cmd.load_bucket = 1'b1;
               state_in        = ST_A_CMP;
            end
         end
         ST_A_CMP: begin
            // earlier bucket: drop the request untouched
            if (status.bucket_before) begin
               state_in = ST_IDLE;
            end else if (status.bucket_same) begin
               state_in = ST_A_UPD;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = swpl_pkg::DIV_GAP;
               state_in      = ST_A_DIV2;
            end
         end
         ST_A_DIV2: begin
            if (status.div_done) begin
               cmd.load_cnt = 1'b1;
               state_in     = ST_A_SHIFT;
            end
         end
         ST_A_SHIFT: begin
            if (status.cnt_zero) begin
               state_in = ST_A_UPD;
            end else begin
               cmd.shift_one = 1'b1;
            end
         end
         ST_A_UPD: begin
            cmd.update_newest = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_Q_DIV1: begin
            if (status.div_done) begin
               // window expired: answer zero
               if (status.quo_expired) begin
                  state_in = ST_Q_ZERO;
               end else begin
                  cmd.load_cnt  = 1'b1;
                  cmd.sum_clear = 1'b1;
                  state_in      = ST_Q_SUM;
               end
            end
         end
         ST_Q_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_last) begin
               state_in = ST_Q_TOT;
            end
         end
         ST_Q_TOT: begin
            if (status.total_zero) begin
               state_in = ST_Q_ZERO;
            end else begin
               cmd.load_product = 1'b1;
               state_in         = ST_Q_MUL;
            end
         end
         ST_Q_MUL: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = swpl_pkg::DIV_RATIO;
            state_in      = ST_Q_DIV2;
         end
         ST_Q_DIV2: begin
            if (status.div_done) begin
               state_in = ST_Q_OUT;
            end
         end
         ST_Q_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_Q_ZERO: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_zero = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/sliding_window_packet_loss_core.sv -----
// Sliding window packet loss meter. One request is handled at a time, and
// req_ready is high only while the core is idle. An account request whose
// bucket is earlier than the newest one is dropped. One that moves to a later
// bucket first shifts the window one slot at a time, at most WINDOW_BUCKETS
// slots. A query sums the window one slot per cycle; an empty or expired
// window answers zero without the loss ratio division, and an expired one
// skips the sum too. The shared 32-step divider makes passes for bucket
// rounding, shift count, query age and loss ratio. A finished response waits
// in an output register, and the next request is accepted meanwhile. A query
// holds in its last cycle while the previous response has not been taken. The
// bucket length register may be written at any time the core is idle; a
// length of zero acts as one second.
module sliding_window_packet_loss_core #(
   parameter int WINDOW_BUCKETS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [swpl_pkg::LEN_W-1:0]        csr_bucket_seconds,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [swpl_pkg::TS_W-1:0]         req_timestamp,
   input  logic [swpl_pkg::FRAME_W-1:0]      req_frame,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [swpl_pkg::LOSS_W-1:0]       rsp_loss_basis_points
);

   swpl_pkg::cmd_type    cmd;
   swpl_pkg::status_type status;

   assign csr_ready = 1'b1;

   swpl_dp #(
      .WINDOW_BUCKETS (WINDOW_BUCKETS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_data      (csr_bucket_seconds),
      .req_op        (req_op),
      .req_timestamp (req_timestamp),
      .req_frame     (req_frame),
      .cmd           (cmd),
      .status        (status),
      .loss          (rsp_loss_basis_points)
   );

   swpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // a response never exceeds 100 percent
   a_loss_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_loss_basis_points <= swpl_pkg::LOSS_W'(10000)))
      else $error("loss result above 10000 basis points");

   // no request is taken while a division is still running
   a_accept_idle_div: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !status.div_busy)
      else $error("request accepted while divider busy");

   // a division only completes while a request is in progress
   a_div_done_busy: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> !req_ready)
      else $error("divider completed with controller idle");

endmodule
